// File: hdl/assert_macros.svh
// Assertion macros shared by the trimmed-mean filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define TMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define TMF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: hdl/tmf_pkg.sv
// Shared constants, types and helpers of the trimmed-mean ADC filter.
package tmf_pkg;

  localparam int DEPTH    = 64;
  localparam int CHANNELS = 8;
  localparam int TRIM     = 10;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W   = $clog2(CHANNELS * DEPTH);

  // Trim that swallows the whole window gives a zero mean.
  localparam bit DEGENERATE = (DEPTH <= 2 * TRIM);
  localparam int KEEP_CNT   = DEGENERATE ? 1 : DEPTH - 2 * TRIM;
  localparam int RANK_LO    = TRIM;
  localparam int RANK_HI    = DEPTH - TRIM;

  localparam int SUM_W = $clog2(DEPTH * ((1 << SAMPLE_W) - 1) + 1);

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] ch;
    logic [PTR_W-1:0]    idx;
  } rd_req_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_IDX_W-1:0] ch,
                                                 input logic [PTR_W-1:0]    idx);
    return ADDR_W'(int'(ch) * DEPTH + int'(idx));
  endfunction

endpackage

// File: hdl/trimmed_mean_adc_filter.sv
// Top level of the trimmed-mean ADC filter.
//
// Input channel (item_valid/item_ready): func, channel, sample. func = store
// writes the sample into the channel's 64-entry circular window; func = query
// asks for the mean of the window after dropping the 10 lowest and 10 highest
// values, truncated. Output channel (result_valid/result_ready): mean_value,
// one item per query, none per store.
// A store writes the sample RAM at the accept edge;
// stores stream at one per clock whenever the block is idle.
// A query walks the window once per sample through the single read port: for
// each of the 64 samples, the pivot is fetched (R_PIVOT, R_CAPTURE), a 64-entry
// compare scan ranks it and an accumulate step adds it if it is in the kept
// band; then the sum is multiplied by the reciprocal of the kept count.
// item_ready stays low until the result is loaded into the output register.
// Out-of-range channels answer zero.
// Reset clears the write pointers and per-channel fill flags; the sample RAM
// is not swept, since unwritten entries read as zero through the fill flags.
// The result sits in an output register: while the receiver stalls, the
// block keeps taking stores, and a finished query waits for the register.

`include "assert_macros.svh"

module trimmed_mean_adc_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          func,
  input  logic [tmf_pkg::CHAN_W-1:0]    channel,
  input  logic [tmf_pkg::SAMPLE_W-1:0]  sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [tmf_pkg::SAMPLE_W-1:0]  mean_value
);

  typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_DIV, ST_HOLD} state_t;

  state_t                       state;
  logic [tmf_pkg::SAMPLE_W-1:0] res;

  logic                         accept;
  logic                         chan_ok;
  logic                         wr_en;
  logic                         rank_start;
  logic [tmf_pkg::CH_IDX_W-1:0] ch_idx;
  tmf_pkg::rd_req_t             rd_req;
  logic [tmf_pkg::SAMPLE_W-1:0] rd_data;
  logic                         rank_done;
  logic [tmf_pkg::SUM_W-1:0]    rank_sum;
  logic                         div_done;
  logic [tmf_pkg::SAMPLE_W-1:0] div_q;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign chan_ok    = (int'(channel) < tmf_pkg::CHANNELS);
  assign ch_idx     = channel[tmf_pkg::CH_IDX_W-1:0];
  assign wr_en      = accept && (func == tmf_pkg::FUNC_STORE) && chan_ok;
  assign rank_start = accept && (func == tmf_pkg::FUNC_QUERY) && chan_ok &&
                      !tmf_pkg::DEGENERATE;

  tmf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_ch   (ch_idx),
    .wr_data (sample),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  tmf_rank u_rank (
    .clk      (clk),
    .rst      (rst),
    .start    (rank_start),
    .start_ch (ch_idx),
    .rd_req   (rd_req),
    .rd_data  (rd_data),
    .done     (rank_done),
    .sum      (rank_sum)
  );

  tmf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rank_done),
    .dividend (rank_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      // in ST_HOLD the register is reloaded below instead
      if (result_valid && result_ready && (state != ST_HOLD)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (func == tmf_pkg::FUNC_QUERY)) begin
            if (rank_start) begin
              state <= ST_RANK;
            end else begin
              // bad channel or trim covering the whole window
              res   <= '0;
              state <= ST_HOLD;
            end
          end
        end
        ST_RANK: begin
          if (rank_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= div_q;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            mean_value   <= res;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TMF_ASSERT_NEVER(a_rd_wr_overlap, rd_req.en && wr_en, "RAM read during store")
  `TMF_ASSERT(a_rank_done_state, rank_done |-> (state == ST_RANK), "rank done out of turn")
  `TMF_ASSERT(a_div_done_state, div_done |-> (state == ST_DIV), "divide done out of turn")

endmodule

// File: hdl/tmf_store.sv
// Sample memory with per-channel write pointers and fill flags.
`include "assert_macros.svh"

module tmf_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tmf_pkg::CH_IDX_W-1:0]  wr_ch,
  input  logic [tmf_pkg::SAMPLE_W-1:0]  wr_data,
  input  tmf_pkg::rd_req_t              rd_req,
  output logic [tmf_pkg::SAMPLE_W-1:0]  rd_data
);

  logic [tmf_pkg::SAMPLE_W-1:0] mem [tmf_pkg::CHANNELS * tmf_pkg::DEPTH];
  logic [tmf_pkg::PTR_W-1:0]    ptr [tmf_pkg::CHANNELS];
  logic [tmf_pkg::CHANNELS-1:0] full;
  logic [tmf_pkg::SAMPLE_W-1:0] rd_q;
  logic                         keep_q;

  // Entries past the pointer of a channel that never wrapped still read as zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tmf_pkg::mem_addr(wr_ch, ptr[wr_ch])] <= wr_data;
    end
    if (rd_req.en) begin
      rd_q   <= mem[tmf_pkg::mem_addr(rd_req.ch, rd_req.idx)];
      keep_q <= full[rd_req.ch] || (rd_req.idx < ptr[rd_req.ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < tmf_pkg::CHANNELS; c++) begin
        ptr[c] <= '0;
      end
      full <= '0;
    end else if (wr_en) begin
      if (ptr[wr_ch] == tmf_pkg::PTR_W'(tmf_pkg::DEPTH - 1)) begin
        ptr[wr_ch]  <= '0;
        full[wr_ch] <= 1'b1;
      end else begin
        ptr[wr_ch] <= ptr[wr_ch] + 1'b1;
      end
    end
  end

  assign rd_data = keep_q ? rd_q : '0;

  `TMF_ASSERT(a_ptr_in_window, wr_en |-> (int'(ptr[wr_ch]) < tmf_pkg::DEPTH), "write pointer out of window")

endmodule

// File: hdl/tmf_rank.sv
// Rank sequencer: finds each sample's sorted position and sums the kept band.
module tmf_rank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tmf_pkg::CH_IDX_W-1:0]  start_ch,
  output tmf_pkg::rd_req_t              rd_req,
  input  logic [tmf_pkg::SAMPLE_W-1:0]  rd_data,
  output logic                          done,
  output logic [tmf_pkg::SUM_W-1:0]     sum
);

  typedef enum logic [2:0] {R_IDLE, R_PIVOT, R_CAPTURE, R_SCAN, R_ACC} state_t;

  state_t                       state;
  logic [tmf_pkg::CH_IDX_W-1:0] ch;
  logic [tmf_pkg::PTR_W-1:0]    piv_idx;
  logic [tmf_pkg::PTR_W-1:0]    cmp_idx;
  logic [tmf_pkg::SAMPLE_W-1:0] pivot;
  logic [tmf_pkg::PTR_W-1:0]    rank;
  logic                         scan_last;
  logic                         less;
  logic                         in_band;

  assign scan_last = (cmp_idx == tmf_pkg::PTR_W'(tmf_pkg::DEPTH - 1));

  // Ties broken by window index so every sample gets a distinct rank.
  assign less = (rd_data < pivot) || ((rd_data == pivot) && (cmp_idx < piv_idx));
  assign in_band = (int'(rank) >= tmf_pkg::RANK_LO) && (int'(rank) < tmf_pkg::RANK_HI);

  always_comb begin
    rd_req.ch  = ch;
    rd_req.en  = 1'b0;
    rd_req.idx = cmp_idx + 1'b1;
    case (state)
      R_PIVOT: begin
        rd_req.en  = 1'b1;
        rd_req.idx = piv_idx;
      end
      R_CAPTURE: begin
        rd_req.en  = 1'b1;
        rd_req.idx = '0;
      end
      R_SCAN: begin
        rd_req.en = !scan_last;
      end
      default: begin
        rd_req.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            ch      <= start_ch;
            piv_idx <= '0;
            sum     <= '0;
            state   <= R_PIVOT;
          end
        end
        R_PIVOT: begin
          state <= R_CAPTURE;
        end
        R_CAPTURE: begin
          pivot   <= rd_data;
          rank    <= '0;
          cmp_idx <= '0;
          state   <= R_SCAN;
        end
        R_SCAN: begin
          rank <= rank + tmf_pkg::PTR_W'(less);
          if (scan_last) begin
            state <= R_ACC;
          end else begin
            cmp_idx <= cmp_idx + 1'b1;
          end
        end
        R_ACC: begin
          if (in_band) begin
            sum <= sum + tmf_pkg::SUM_W'(pivot);
          end
          if (piv_idx == tmf_pkg::PTR_W'(tmf_pkg::DEPTH - 1)) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            piv_idx <= piv_idx + 1'b1;
            state   <= R_PIVOT;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/tmf_div.sv
// Divider by the kept-sample count, built as a constant reciprocal multiply.
`include "assert_macros.svh"

module tmf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tmf_pkg::SUM_W-1:0]     dividend,
  output logic                          done,
  output logic [tmf_pkg::SAMPLE_W-1:0]  quotient
);

  // floor(x / KEEP_CNT) == (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int     SHIFT  = tmf_pkg::SUM_W + $clog2(tmf_pkg::KEEP_CNT);
  localparam longint RECIP  = ((longint'(1) << SHIFT) + longint'(tmf_pkg::KEEP_CNT) - 1) /
                              longint'(tmf_pkg::KEEP_CNT);
  localparam int     PROD_W = 2 * tmf_pkg::SUM_W + 1;

  logic                       busy;
  logic [tmf_pkg::SUM_W-1:0]  dvd;
  logic [PROD_W-1:0]          prod;

  assign prod = PROD_W'(dvd) * PROD_W'(RECIP);

  // Sum registered on start, quotient registered in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
      end else if (busy) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= prod[SHIFT +: tmf_pkg::SAMPLE_W];
      end
    end
  end

  `TMF_ASSERT_NEVER(a_start_while_busy, start && busy, "divider restarted while busy")

endmodule
